[rtl/mwc_pkg.sv]
// shared types, constants and target decode functions for the window cover block
`default_nettype none
package mwc_pkg;

  localparam int TARGET_SLOTS = 8;
  localparam int SLOT_W       = $clog2(TARGET_SLOTS);
  localparam int WINDOW_DEPTH = 256;
  localparam int QADDR_W      = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = QADDR_W + 1;
  localparam int POS_W        = 16;
  localparam int LEN_W        = POS_W + 1;
  localparam int HAVE_W       = FILL_W;
  localparam int CNT_W        = 4;
  localparam int ENTRY_W      = SLOT_W + POS_W;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [POS_W-1:0] MAX_LENGTH = 16'hFFFF;

  localparam logic [0:0] REG_TARGET_SYMBOLS = 1'b0;
  localparam logic [0:0] REG_TARGET_SIZE    = 1'b1;

  typedef struct packed {
    logic [63:0] symbols;
    logic [3:0]  size;
  } cfg_t;

  typedef struct packed {
    logic              member;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              pos_ovf;
  } item_t;

  function automatic logic [CNT_W-1:0] used_slots(input logic [3:0] size);
    logic [CNT_W-1:0] n;
    n = size;
    if (size == 4'd0) n = 4'd1;
    if (size > 4'(TARGET_SLOTS)) n = 4'(TARGET_SLOTS);
    return n;
  endfunction

  function automatic logic [7:0] slot_byte(input logic [63:0] symbols, input int i);
    return symbols[8*i +: 8];
  endfunction

  // occurrences of slot j's character among the used slots
  function automatic logic [CNT_W-1:0] need_of(input cfg_t cfg, input int j);
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] cnt;
    n = used_slots(cfg.size);
    cnt = '0;
    for (int i = 0; i < TARGET_SLOTS; i++) begin
      if ((CNT_W'(i) < n) && (slot_byte(cfg.symbols, i) == slot_byte(cfg.symbols, j))) begin
        cnt = cnt + 1'b1;
      end
    end
    return cnt;
  endfunction

  function automatic logic [CNT_W-1:0] distinct_of(input cfg_t cfg);
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] cnt;
    logic             first;
    n = used_slots(cfg.size);
    cnt = '0;
    for (int i = 0; i < TARGET_SLOTS; i++) begin
      first = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (slot_byte(cfg.symbols, j) == slot_byte(cfg.symbols, i)) first = 1'b0;
      end
      if ((CNT_W'(i) < n) && first) cnt = cnt + 1'b1;
    end
    return cnt;
  endfunction

endpackage
`default_nettype wire

[rtl/mwc_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module mwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/mwc_fifo.sv]
// short queue of classified beats between front and back
`default_nettype none
module mwc_fifo import mwc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  flush,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output item_t      head_item
);

  item_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/mwc_front.sv]
// front end: position counter and target slot lookup per beat
`default_nettype none
module mwc_front import mwc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       clear,
  input  wire cfg_t       cfg,
  input  wire logic       sym_valid,
  output logic            sym_stall,
  input  wire logic [7:0] symbol,
  input  wire logic       last,
  input  wire logic       q_pop,
  output logic            q_valid,
  output item_t           q_item
);

  logic [POS_W:0]     position;
  logic               accept;
  logic               full;
  item_t              item;
  logic [CNT_W-1:0]   n;
  logic               hit;
  logic [SLOT_W-1:0]  owner;

  assign sym_stall = full;
  assign accept    = sym_valid && !full;
  assign n         = used_slots(cfg.size);

  always_comb begin
    hit   = 1'b0;
    owner = '0;
    for (int i = 0; i < TARGET_SLOTS; i++) begin
      if (!hit && (CNT_W'(i) < n) && (slot_byte(cfg.symbols, i) == symbol)) begin
        hit   = 1'b1;
        owner = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    item.member  = hit;
    item.slot    = owner;
    item.last    = last;
    item.pos_ovf = position[POS_W];
    item.pos     = position[POS_W] ? MAX_LENGTH : position[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      position <= '0;
    end else if (accept) begin
      if (last) begin
        position <= '0;
      end else if (!position[POS_W]) begin
        position <= position + 1'b1;
      end
    end
  end

  mwc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .flush      (clear),
    .push       (accept),
    .push_item  (item),
    .full       (full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

endmodule
`default_nettype wire

[rtl/mwc_back.sv]
// back end: window queue, have counts, shrink loop and result register
`default_nettype none
module mwc_back import mwc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        clear,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             found,
  output logic [15:0]      best_length,
  output logic [15:0]      best_start,
  output logic [15:0]      best_end,
  output logic             overflow
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVICT  = 6'b000010,
    S_PUSH   = 6'b000100,
    S_FETCH  = 6'b001000,
    S_SHRINK = 6'b010000,
    S_REPORT = 6'b100000
  } state_t;

  state_t              state;
  state_t              state_next;
  item_t               cur;
  item_t               it;
  logic [HAVE_W-1:0]   have [TARGET_SLOTS];
  logic [CNT_W-1:0]    need [TARGET_SLOTS];
  logic [CNT_W-1:0]    distinct;
  logic [QADDR_W-1:0]  head;
  logic [FILL_W-1:0]   fill;
  logic [CNT_W-1:0]    sat;
  logic                best_valid;
  logic [LEN_W-1:0]    best_len;
  logic [POS_W-1:0]    best_from;
  logic [POS_W-1:0]    best_to;
  logic                ovf;

  logic                take;
  logic                do_push;
  logic                do_pop;
  logic                queue_full;
  logic [QADDR_W-1:0]  raddr;
  logic [QADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0]  rdata;
  logic [SLOT_W-1:0]   rd_slot;
  logic [POS_W-1:0]    rd_pos;
  logic [SLOT_W-1:0]   cnt_idx;
  logic [HAVE_W-1:0]   have_sel;
  logic [HAVE_W-1:0]   need_sel;
  logic [HAVE_W-1:0]   have_inc;
  logic [CNT_W-1:0]    sat_push;
  logic                pop_ok;
  logic [CNT_W-1:0]    sat_pop;
  logic [LEN_W-1:0]    len;
  logic                better;
  logic                out_free;

  always_comb begin
    for (int j = 0; j < TARGET_SLOTS; j++) begin
      need[j] = need_of(cfg, j);
    end
    distinct = distinct_of(cfg);
  end

  assign it         = (state == S_IDLE) ? q_item : cur;
  assign take       = (state == S_IDLE) && q_valid;
  assign q_pop      = take;
  assign queue_full = (fill == FILL_W'(WINDOW_DEPTH));
  assign do_push    = (take && it.member && !queue_full) || (state == S_PUSH);
  assign do_pop     = (state == S_EVICT) || (state == S_SHRINK);

  assign rd_slot = rdata[ENTRY_W-1:POS_W];
  assign rd_pos  = rdata[POS_W-1:0];
  assign raddr   = (state == S_SHRINK) ? head + 1'b1 : head;
  assign waddr   = head + fill[QADDR_W-1:0];

  assign cnt_idx  = do_pop ? rd_slot : it.slot;
  assign have_sel = have[cnt_idx];
  assign need_sel = HAVE_W'(need[cnt_idx]);
  assign have_inc = have_sel + 1'b1;
  assign sat_push = sat + CNT_W'(have_inc == need_sel);
  assign pop_ok   = (have_sel != '0);
  assign sat_pop  = sat - CNT_W'(pop_ok && (have_sel == need_sel) && (sat != '0));

  assign len    = {1'b0, it.pos} - {1'b0, rd_pos} + 1'b1;
  assign better = !best_valid || (len < best_len);

  assign out_free = !res_valid || !res_stall;

  mwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (do_push),
    .waddr (waddr),
    .wdata ({it.slot, it.pos}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (!it.member) begin
            state_next = it.last ? S_REPORT : S_IDLE;
          end else if (queue_full) begin
            state_next = S_EVICT;
          end else if (sat_push >= distinct) begin
            state_next = S_FETCH;
          end else begin
            state_next = it.last ? S_REPORT : S_IDLE;
          end
        end
      end
      S_EVICT: state_next = S_PUSH;
      S_PUSH: begin
        if (sat_push >= distinct) begin
          state_next = S_FETCH;
        end else begin
          state_next = it.last ? S_REPORT : S_IDLE;
        end
      end
      S_FETCH: state_next = S_SHRINK;
      S_SHRINK: begin
        if ((sat_pop >= distinct) && (fill != FILL_W'(1))) begin
          state_next = S_SHRINK;
        end else begin
          state_next = it.last ? S_REPORT : S_IDLE;
        end
      end
      S_REPORT: state_next = out_free ? S_IDLE : S_REPORT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_item;
    end
    if (state == S_SHRINK && better) begin
      best_len  <= len;
      best_from <= rd_pos;
      best_to   <= it.pos;
    end
    if (state == S_REPORT && out_free) begin
      found       <= best_valid;
      best_length <= !best_valid ? 16'd0 : (best_len[POS_W] ? 16'hFFFF : best_len[POS_W-1:0]);
      best_start  <= best_valid ? best_from : 16'd0;
      best_end    <= best_valid ? best_to : 16'd0;
      overflow    <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= clear ? S_IDLE : state_next;
      if (state == S_REPORT && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear || (state == S_REPORT && out_free)) begin
      for (int j = 0; j < TARGET_SLOTS; j++) begin
        have[j] <= '0;
      end
      head       <= '0;
      fill       <= '0;
      sat        <= '0;
      best_valid <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      if (take && it.pos_ovf) ovf <= 1'b1;
      if (state == S_EVICT) ovf <= 1'b1;
      if (do_push) begin
        have[cnt_idx] <= have_inc;
        sat           <= sat_push;
        fill          <= fill + 1'b1;
      end else if (do_pop) begin
        if (pop_ok) have[cnt_idx] <= have_sel - 1'b1;
        sat  <= sat_pop;
        head <= head + 1'b1;
        fill <= fill - 1'b1;
      end
      if (state == S_SHRINK) best_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/minimum_window_cover.sv]
// top level of the shortest covering window finder: config registers and the two halves
//
//  channel   | signals                                    | beat taken when
//  ----------+--------------------------------------------+-------------------------
//  symbols   | sym_valid sym_stall symbol last            | sym_valid && !sym_stall
//  results   | res_valid res_stall found best_length      | res_valid && !res_stall
//            | best_start best_end overflow               |
//  config    | cfg_we cfg_index cfg_data                  | cfg_we
//
// a symbol outside the target, or one leaving the window uncovered, needs only the idle
// state in the back end; a covering symbol goes to fetch, then shrink, which pops one
// queue entry a step; a full queue adds evict and push; the ram read port sets that pace
// after the last beat, report loads the result register, which holds while stalled
// synchronous reset clears all control state; a config write clears the stream state
// a four entry queue lets the front take beats while the back is shrinking
`default_nettype none
module minimum_window_cover import mwc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sym_valid,
  output logic             sym_stall,
  input  wire logic [7:0]  symbol,
  input  wire logic        last,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             found,
  output logic [15:0]      best_length,
  output logic [15:0]      best_start,
  output logic [15:0]      best_end,
  output logic             overflow,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.symbols <= '0;
      cfg.size    <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_SYMBOLS: cfg.symbols <= cfg_data;
        REG_TARGET_SIZE:    cfg.size    <= cfg_data[3:0];
        default:            cfg.size    <= cfg.size;
      endcase
    end
  end

  mwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .cfg       (cfg),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .symbol    (symbol),
    .last      (last),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  mwc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .clear       (cfg_we),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .found       (found),
    .best_length (best_length),
    .best_start  (best_start),
    .best_end    (best_end),
    .overflow    (overflow)
  );

endmodule
`default_nettype wire
